// ===== design/multichannel_second_difference_core_macros.svh =====
// Assertion macros for the multichannel second difference core checker.
// Clocked on clk, disabled while rst is high.
`ifndef MULTICHANNEL_SECOND_DIFFERENCE_CORE_MACROS_SVH
`define MULTICHANNEL_SECOND_DIFFERENCE_CORE_MACROS_SVH

// holds in the same cycle
`define MSD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("msd check failed");

// holds in the next cycle
`define MSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("msd check failed");

`endif

// ===== design/msd_pkg.sv =====
// Shared constants and types for the multichannel second difference core.
// No dependencies.
`default_nettype none

package msd_pkg;

  localparam int CHANNELS    = 64;
  localparam int SAMPLE_BITS = 24;
  localparam int CHAN_W      = 6;
  localparam int ADDR_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DIFF_W      = SAMPLE_BITS + 1;
  localparam int OUT_W       = SAMPLE_BITS + 2;
  localparam int SEEN_W      = 2;

  localparam logic [SEEN_W-1:0] SEEN_NONE = 2'd0;
  localparam logic [SEEN_W-1:0] SEEN_ONE  = 2'd1;
  localparam logic [SEEN_W-1:0] SEEN_WARM = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic signed [DIFF_W-1:0]      diff;
    logic [SEEN_W-1:0]             seen;
  } chan_state_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    chan_state_t       data;
  } wr_req_t;

endpackage

`default_nettype wire

// ===== design/multichannel_second_difference_core.sv =====
// Channel  Handshake          Beat fields
// input    in_valid/in_stall  channel, sample
// output   out_valid/out_stall out_channel, second_diff, warming_up
//
// One beat per cycle sustained unless out_stall holds the output stage.
// Stage 1 reads the channel's state from memory, stage 2 computes and writes back.
// Same-channel beats in consecutive cycles are forwarded from the last write.
// Reset clears the warm-up tracking at once; no clearing pass.
// in_stall follows out_stall only when both stages are full; it is also high in reset.
`default_nettype none

module multichannel_second_difference_core (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire  [msd_pkg::CHAN_W-1:0]            channel,
  input  wire  signed [msd_pkg::SAMPLE_BITS-1:0] sample,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic [msd_pkg::CHAN_W-1:0]            out_channel,
  output logic signed [msd_pkg::OUT_W-1:0]      second_diff,
  output logic                                  warming_up
);
  import msd_pkg::*;

  logic                          accept;
  logic                          out_free;
  logic                          s1_adv;
  logic                          s1_valid;
  logic [CHAN_W-1:0]             s1_chan;
  logic signed [SAMPLE_BITS-1:0] s1_sample;
  logic                          s1_in_range;
  rd_req_t                       rd;
  wr_req_t                       wr;
  chan_state_t                   cur;
  logic signed [DIFF_W-1:0]      d;
  logic signed [OUT_W-1:0]       res;
  logic                          warm;
  logic [SEEN_W-1:0]             seen_next;

  assign out_free = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && out_free;
  assign in_stall = rst || (s1_valid && !out_free);
  assign accept   = in_valid && !in_stall;

  assign rd.en   = accept;
  assign rd.addr = ADDR_W'(channel);

  msd_state_store u_store (
    .clk      (clk),
    .rst      (rst),
    .rd       (rd),
    .wr       (wr),
    .rd_state (cur)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_chan     <= channel;
      s1_sample   <= sample;
      s1_in_range <= ({3'b000, channel} < 9'(CHANNELS));
    end
  end

  always_comb begin
    d    = {s1_sample[SAMPLE_BITS-1], s1_sample} - {cur.sample[SAMPLE_BITS-1], cur.sample};
    res  = {d[DIFF_W-1], d} - {cur.diff[DIFF_W-1], cur.diff};
    warm = !s1_in_range || (cur.seen == SEEN_NONE) || (cur.seen == SEEN_ONE);
    case (cur.seen)
      SEEN_NONE: seen_next = SEEN_ONE;
      SEEN_ONE:  seen_next = SEEN_WARM;
      default:   seen_next = cur.seen;
    endcase
  end

  always_comb begin
    wr.en          = s1_adv && s1_in_range;
    wr.addr        = ADDR_W'(s1_chan);
    wr.data.sample = s1_sample;
    wr.data.diff   = (cur.seen == SEEN_NONE) ? cur.diff : d;
    wr.data.seen   = seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_channel <= s1_chan;
      second_diff <= warm ? '0 : res;
      warming_up  <= warm;
    end
  end

endmodule

`default_nettype wire

// ===== design/msd_state_store.sv =====
// Per-channel state memory: registered read, write-to-read forwarding,
// and reset-cleared written bits. Depends on msd_pkg.
`default_nettype none

module msd_state_store (
  input  wire                  clk,
  input  wire                  rst,
  input  msd_pkg::rd_req_t     rd,
  input  msd_pkg::wr_req_t     wr,
  output msd_pkg::chan_state_t rd_state
);
  import msd_pkg::*;

  chan_state_t       mem [CHANNELS];
  logic [CHANNELS-1:0] written;
  chan_state_t       mem_q;
  logic              written_q;
  logic [ADDR_W-1:0] rd_addr_q;
  wr_req_t           last_wr;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      mem_q     <= mem[rd.addr];
      written_q <= written[rd.addr];
      rd_addr_q <= rd.addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      last_wr.en <= 1'b0;
    end else if (wr.en) begin
      written[wr.addr] <= 1'b1;
      last_wr          <= wr;
    end
  end

  // a write landing on the read edge is not seen by the memory read
  always_comb begin
    rd_state = mem_q;
    if (last_wr.en && (last_wr.addr == rd_addr_q)) begin
      rd_state = last_wr.data;
    end else if (!written_q) begin
      rd_state.seen = SEEN_NONE;
    end
  end

endmodule

`default_nettype wire

// ===== design/msd_checker.sv =====
// Port-level checks for the multichannel second difference core, bound to the top.
// Depends on msd_pkg and the assertion macro header.
`default_nettype none
`include "multichannel_second_difference_core_macros.svh"

module msd_checker (
  input wire                                   clk,
  input wire                                   rst,
  input wire                                   in_valid,
  input wire                                   in_stall,
  input wire  [msd_pkg::CHAN_W-1:0]            channel,
  input wire  signed [msd_pkg::SAMPLE_BITS-1:0] sample,
  input wire                                   out_valid,
  input wire                                   out_stall,
  input wire  [msd_pkg::CHAN_W-1:0]            out_channel,
  input wire  signed [msd_pkg::OUT_W-1:0]      second_diff,
  input wire                                   warming_up
);
  import msd_pkg::*;

  logic in_beat;
  assign in_beat = in_valid && !in_stall && (channel == channel) && (sample == sample);

  `MSD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_channel) && $stable(second_diff) && $stable(warming_up))
  `MSD_ASSERT_NOW(a_warm_zero, out_valid && warming_up, second_diff == '0)
  `MSD_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)
  `MSD_ASSERT_NEXT(a_latency, in_beat ##1 !out_stall, out_valid)

endmodule

bind multichannel_second_difference_core msd_checker u_msd_checker (.*);

`default_nettype wire
